[rtl/tts_pkg.sv]
package tts_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = $clog2(MAX_ROWS);
  localparam int CNT_W     = $clog2(MAX_ROWS + 1);
  localparam int PROD_W    = 2 * DATA_W;
  localparam int NUM_W     = PROD_W + 1 - FRAC_BITS;
  localparam int DVD_W     = NUM_W + FRAC_BITS;
  localparam int QUO_W     = DATA_W + 1;
  localparam int FLAG_ZERO = 0;
  localparam int FLAG_SAT  = 1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_ZERO = 2'd2,
    ST_SAT  = 2'd3
  } status_code_t;

  typedef struct packed {
    logic              load;
    logic              first;
    logic              div_fwd;
    logic              div_bk;
    logic              m_take;
    logic              mul_up;
    logic              piv_wr;
    logic              mul_rhs;
    logic              rhs_wr;
    logic              rd;
    logic              bk_mul;
    logic              bk_first;
    logic              emit;
    logic              emit_err;
    logic              emit_last;
    logic              clr;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic div_busy;
  } dp_status_t;

  function automatic logic [DATA_W:0] sat_num(input logic signed [NUM_W-1:0] v);
    logic [NUM_W-DATA_W:0] hi;
    hi = v[NUM_W-1:DATA_W-1];
    if (hi == '0 || hi == '1) begin
      return {1'b0, v[DATA_W-1:0]};
    end else if (v[NUM_W-1]) begin
      return {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  function automatic status_code_t status_of(input logic [1:0] flags);
    if (flags[FLAG_ZERO]) begin
      return ST_ZERO;
    end else if (flags[FLAG_SAT]) begin
      return ST_SAT;
    end else begin
      return ST_OK;
    end
  endfunction

endpackage

[rtl/tts_divider.sv]
module tts_divider (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic signed [tts_pkg::NUM_W-1:0]        num,
  input  logic signed [tts_pkg::DATA_W-1:0]       den,
  output logic                                    busy,
  output logic                                    done,
  output logic signed [tts_pkg::DATA_W-1:0]       quo,
  output logic                                    zero_flag,
  output logic                                    sat_flag
);
  import tts_pkg::*;

  localparam int ITER_W = $clog2(QUO_W + 1);

  logic [NUM_W-1:0]  num_mag;
  logic [DATA_W-1:0] den_mag;
  logic [DVD_W-1:0]  dvd;
  logic              ovf;
  logic [QUO_W-1:0]  trial;
  logic              ge;
  logic [QUO_W-1:0]  qn;
  logic [QUO_W-1:0]  rem_sub;
  logic              pos_ovf;
  logic              neg_ovf;

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [QUO_W-1:0]  work_r;
  logic [DATA_W-1:0] dmag_r;
  logic              neg_r;
  logic [DATA_W-1:0] quo_r;
  logic              zf_r;
  logic              sf_r;

  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign den_mag = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
  assign dvd     = {num_mag, {FRAC_BITS{1'b0}}};
  assign ovf     = dvd[DVD_W-1:QUO_W] >= den_mag;
  assign trial   = {rem_r, work_r[QUO_W-1]};
  assign ge      = trial >= {1'b0, dmag_r};
  assign rem_sub = trial - {1'b0, dmag_r};
  assign qn      = {work_r[QUO_W-2:0], ge};
  assign pos_ovf = qn[QUO_W-1] | qn[QUO_W-2];
  assign neg_ovf = qn[QUO_W-1] | (qn[QUO_W-2] & (|qn[QUO_W-3:0]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        neg_r  <= num[NUM_W-1] ^ den[DATA_W-1];
        dmag_r <= den_mag;
        rem_r  <= dvd[DVD_W-1:QUO_W];
        work_r <= dvd[QUO_W-1:0];
        if (den == '0) begin
          done_r <= 1'b1;
          quo_r  <= '0;
          zf_r   <= 1'b1;
          sf_r   <= 1'b0;
        end else if (ovf) begin
          done_r <= 1'b1;
          zf_r   <= 1'b0;
          sf_r   <= 1'b1;
          quo_r  <= (num[NUM_W-1] ^ den[DATA_W-1]) ? {1'b1, {(DATA_W-1){1'b0}}}
                                                    : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= ITER_W'(QUO_W);
        end
      end else if (busy_r) begin
        rem_r  <= ge ? rem_sub[DATA_W-1:0] : trial[DATA_W-1:0];
        work_r <= qn;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          zf_r   <= 1'b0;
          if (!neg_r) begin
            sf_r  <= pos_ovf;
            quo_r <= pos_ovf ? {1'b0, {(DATA_W-1){1'b1}}} : qn[DATA_W-1:0];
          end else begin
            sf_r  <= neg_ovf;
            quo_r <= neg_ovf ? {1'b1, {(DATA_W-1){1'b0}}} : DATA_W'(-qn[DATA_W-1:0]);
          end
        end
      end
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quo       = quo_r;
  assign zero_flag = zf_r;
  assign sat_flag  = sf_r;

endmodule

[rtl/tts_datapath.sv]
module tts_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tts_pkg::cmd_t                       cmd,
  output tts_pkg::dp_status_t                 st,
  input  logic signed [tts_pkg::DATA_W-1:0]   in_lower_coef,
  input  logic signed [tts_pkg::DATA_W-1:0]   in_main_coef,
  input  logic signed [tts_pkg::DATA_W-1:0]   in_upper_coef,
  input  logic signed [tts_pkg::DATA_W-1:0]   in_rhs_value,
  output logic                                out_strobe,
  output logic [tts_pkg::ADDR_W-1:0]          out_row_index,
  output logic signed [tts_pkg::DATA_W-1:0]   out_solution,
  output logic [1:0]                          out_status,
  output logic                                out_last_result
);
  import tts_pkg::*;

  logic [DATA_W-1:0] upper_mem [MAX_ROWS];
  logic [DATA_W-1:0] pivot_mem [MAX_ROWS];
  logic [DATA_W-1:0] rhs_mem   [MAX_ROWS];

  logic signed [DATA_W-1:0] lo_r, mn_r, up_r, rh_r;
  logic signed [DATA_W-1:0] prev_piv_r, prev_up_r, prev_rhs_r;
  logic signed [DATA_W-1:0] m_r, next_r;
  logic signed [DATA_W-1:0] rd_up_r, rd_piv_r, rd_rhs_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [1:0]               flags_r;
  logic [1:0]               flags_nxt;
  logic                     strobe_r;
  logic [ADDR_W-1:0]        idx_out_r;
  logic [DATA_W-1:0]        sol_r;
  logic [1:0]               stat_r;
  logic                     last_r;

  logic signed [NUM_W-1:0]  prod_sh;
  logic signed [NUM_W-1:0]  piv_diff;
  logic signed [NUM_W-1:0]  rhs_diff;
  logic signed [NUM_W-1:0]  bk_num;
  logic [DATA_W:0]          piv_sat;
  logic [DATA_W:0]          rhs_sat;
  logic signed [NUM_W-1:0]  div_num;
  logic signed [DATA_W-1:0] div_den;
  logic                     div_start;
  logic                     div_busy;
  logic                     div_done;
  logic signed [DATA_W-1:0] div_quo;
  logic                     div_zf;
  logic                     div_sf;

  assign prod_sh  = NUM_W'($signed(prod_r[PROD_W-1:FRAC_BITS]));
  assign piv_diff = NUM_W'(mn_r) - prod_sh;
  assign rhs_diff = NUM_W'(rh_r) - prod_sh;
  assign bk_num   = NUM_W'(rd_rhs_r) - prod_sh;
  assign piv_sat  = sat_num(piv_diff);
  assign rhs_sat  = sat_num(rhs_diff);

  assign div_start = cmd.div_fwd | cmd.div_bk;
  assign div_num   = cmd.div_bk ? bk_num : NUM_W'(lo_r);
  assign div_den   = cmd.div_bk ? rd_piv_r : prev_piv_r;

  tts_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .num       (div_num),
    .den       (div_den),
    .busy      (div_busy),
    .done      (div_done),
    .quo       (div_quo),
    .zero_flag (div_zf),
    .sat_flag  (div_sf)
  );

  assign st.div_done = div_done;
  assign st.div_busy = div_busy;

  always_comb begin
    flags_nxt = flags_r;
    if (cmd.clr) begin
      flags_nxt = '0;
    end else if (cmd.m_take || cmd.emit) begin
      flags_nxt = flags_r | {div_sf, div_zf};
    end else if (cmd.piv_wr) begin
      flags_nxt = flags_r | {piv_sat[DATA_W], 1'b0};
    end else if (cmd.rhs_wr) begin
      flags_nxt = flags_r | {rhs_sat[DATA_W], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      upper_mem[cmd.addr] <= in_upper_coef;
    end
    if (cmd.first) begin
      pivot_mem[cmd.addr] <= mn_r;
      rhs_mem[cmd.addr]   <= rh_r;
    end
    if (cmd.piv_wr) begin
      pivot_mem[cmd.addr] <= piv_sat[DATA_W-1:0];
    end
    if (cmd.rhs_wr) begin
      rhs_mem[cmd.addr] <= rhs_sat[DATA_W-1:0];
    end
    if (cmd.rd) begin
      rd_up_r  <= upper_mem[cmd.addr];
      rd_piv_r <= pivot_mem[cmd.addr];
      rd_rhs_r <= rhs_mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_r <= in_lower_coef;
      mn_r <= in_main_coef;
      up_r <= in_upper_coef;
      rh_r <= in_rhs_value;
    end
    if (cmd.first) begin
      prev_piv_r <= mn_r;
      prev_rhs_r <= rh_r;
      prev_up_r  <= up_r;
    end
    if (cmd.m_take) begin
      m_r <= div_quo;
    end
    if (cmd.mul_up) begin
      prod_r <= m_r * prev_up_r;
    end
    if (cmd.piv_wr) begin
      prev_piv_r <= piv_sat[DATA_W-1:0];
    end
    if (cmd.mul_rhs) begin
      prod_r <= m_r * prev_rhs_r;
    end
    if (cmd.rhs_wr) begin
      prev_rhs_r <= rhs_sat[DATA_W-1:0];
      prev_up_r  <= up_r;
    end
    if (cmd.bk_mul) begin
      if (cmd.bk_first) begin
        prod_r <= '0;
      end else begin
        prod_r <= rd_up_r * next_r;
      end
    end
    if (cmd.emit) begin
      next_r    <= div_quo;
      idx_out_r <= cmd.addr;
      sol_r     <= div_quo;
      stat_r    <= status_of(flags_r | {div_sf, div_zf});
      last_r    <= cmd.emit_last;
    end
    if (cmd.emit_err) begin
      idx_out_r <= '0;
      sol_r     <= '0;
      stat_r    <= ST_FEW;
      last_r    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      flags_r  <= flags_nxt;
      strobe_r <= cmd.emit | cmd.emit_err;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_row_index   = idx_out_r;
  assign out_solution    = sol_r;
  assign out_status      = stat_r;
  assign out_last_result = last_r;

endmodule

[rtl/tts_ctrl.sv]
module tts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_last_row,
  output logic                busy,
  output tts_pkg::cmd_t       cmd,
  input  tts_pkg::dp_status_t st
);
  import tts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_FDIV, S_FWAIT, S_MULA, S_PIVW, S_MULB, S_RHSW,
    S_CHECK, S_ERR, S_BREAD, S_BMUL, S_BDIV, S_BWAIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              last_r, last_nxt;
  logic              accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.addr  = idx_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.addr = cnt_r[ADDR_W-1:0];
        if (accept) begin
          cmd.load  = 1'b1;
          idx_nxt   = cnt_r[ADDR_W-1:0];
          cnt_nxt   = cnt_r + 1'b1;
          last_nxt  = in_last_row;
          state_nxt = (cnt_r == '0) ? S_FIRST : S_FDIV;
        end
      end
      S_FIRST: begin
        cmd.first = 1'b1;
        state_nxt = S_CHECK;
      end
      S_FDIV: begin
        cmd.div_fwd = 1'b1;
        state_nxt   = S_FWAIT;
      end
      S_FWAIT: begin
        if (st.div_done) begin
          cmd.m_take = 1'b1;
          state_nxt  = S_MULA;
        end
      end
      S_MULA: begin
        cmd.mul_up = 1'b1;
        state_nxt  = S_PIVW;
      end
      S_PIVW: begin
        cmd.piv_wr = 1'b1;
        state_nxt  = S_MULB;
      end
      S_MULB: begin
        cmd.mul_rhs = 1'b1;
        state_nxt   = S_RHSW;
      end
      S_RHSW: begin
        cmd.rhs_wr = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_CHECK: begin
        if (!(last_r || cnt_r >= CNT_W'(MAX_ROWS))) begin
          state_nxt = S_IDLE;
        end else if (cnt_r < CNT_W'(2)) begin
          state_nxt = S_ERR;
        end else begin
          idx_nxt   = ADDR_W'(cnt_r - 1'b1);
          state_nxt = S_BREAD;
        end
      end
      S_ERR: begin
        cmd.emit_err = 1'b1;
        cmd.clr      = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_IDLE;
      end
      S_BREAD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_BMUL;
      end
      S_BMUL: begin
        cmd.bk_mul   = 1'b1;
        cmd.bk_first = ({1'b0, idx_r} == CNT_W'(cnt_r - 1'b1));
        state_nxt    = S_BDIV;
      end
      S_BDIV: begin
        cmd.div_bk = 1'b1;
        state_nxt  = S_BWAIT;
      end
      S_BWAIT: begin
        if (st.div_done) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = (idx_r == '0);
          if (idx_r == '0) begin
            cmd.clr   = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = S_BREAD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      last_r  <= last_nxt;
    end
  end

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !st.div_busy)
    else $error("divider busy while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("no work after transfer");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cnt_r < CNT_W'(MAX_ROWS)))
    else $error("row count at capacity while idle");

  a_solve_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.emit_last) |=> (state_r == S_IDLE && cnt_r == '0))
    else $error("solve did not end after last result");

endmodule

[rtl/tridiagonal_thomas_solver.sv]
// Thomas-algorithm tridiagonal solver, signed Q16.16. Rows are transferred one
// per start/!busy handshake; busy stays high until a row has been worked in,
// which for each row after row 0 takes the 33-step restoring divider to form
// its multiplier. After the last row (or the row that fills 64), one result per
// unknown comes out from the last row down to row 0, paced by the divider; with
// fewer than two rows a single result with status ST_FEW comes out instead.
// Results appear on out_strobe for exactly one cycle: the receiver cannot stall,
// so it must take every strobe.
module tridiagonal_thomas_solver (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [tts_pkg::DATA_W-1:0]   in_lower_coef,
  input  logic signed [tts_pkg::DATA_W-1:0]   in_main_coef,
  input  logic signed [tts_pkg::DATA_W-1:0]   in_upper_coef,
  input  logic signed [tts_pkg::DATA_W-1:0]   in_rhs_value,
  input  logic                                in_last_row,
  output logic                                out_strobe,
  output logic [tts_pkg::ADDR_W-1:0]          out_row_index,
  output logic signed [tts_pkg::DATA_W-1:0]   out_solution,
  output logic [1:0]                          out_status,
  output logic                                out_last_result
);
  import tts_pkg::*;

  cmd_t       cmd;
  dp_status_t st;

  tts_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_last_row (in_last_row),
    .busy        (busy),
    .cmd         (cmd),
    .st          (st)
  );

  tts_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_lower_coef   (in_lower_coef),
    .in_main_coef    (in_main_coef),
    .in_upper_coef   (in_upper_coef),
    .in_rhs_value    (in_rhs_value),
    .out_strobe      (out_strobe),
    .out_row_index   (out_row_index),
    .out_solution    (out_solution),
    .out_status      (out_status),
    .out_last_result (out_last_result)
  );

endmodule
